### rtl/core/proximity_haptic_alert_controller_unit_assert.svh
// Assertion macros shared by the controller's RTL files.
// No dependencies; each file that checks itself includes this header.
`ifndef PROXIMITY_HAPTIC_ALERT_CONTROLLER_UNIT_ASSERT_SVH
`define PROXIMITY_HAPTIC_ALERT_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PHAC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("phac assertion failed");

// Next-cycle implication, disabled during reset.
`define PHAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("phac assertion failed");

`endif

### rtl/core/phac_pkg.sv
// Shared types, register indexes and pattern helpers for the haptic alert controller.
// No dependencies.
package phac_pkg;

   localparam int unsigned DIST_W   = 12;
   localparam int unsigned LIMIT_W  = 16;
   localparam int unsigned ACCEL_W  = 8;
   localparam int unsigned MAG_W    = 17;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned Q_DEPTH  = 4;
   localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_CM     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_CM    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GESTURE_CM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRASH_LIMIT = 3'd4;

   localparam logic [DIST_W-1:0]  NEAR_RST  = 12'd10;
   localparam logic [DIST_W-1:0]  CLEAR_RST = 12'd20;
   localparam logic [DIST_W-1:0]  GEST_RST  = 12'd5;
   localparam logic [LIMIT_W-1:0] TILT_RST  = 16'd4000;
   localparam logic [LIMIT_W-1:0] CRASH_RST = 16'd14400;

   // haptic pattern steps
   localparam logic [3:0] STEP_IDLE  = 4'd0;
   localparam logic [3:0] STEP_MID   = 4'd1;
   localparam logic [3:0] STEP_RIGHT = 4'd4;
   localparam logic [3:0] STEP_LEFT  = 4'd7;
   localparam logic [3:0] STEP_LAST  = 4'd9;
   localparam logic [1:0] HOLD_LAST  = 2'd2;
   localparam logic [3:0] BLINK_END  = 4'd9;
   localparam logic [3:0] SOS_TICK   = 4'd10;
   localparam logic [3:0] SOS_RELOAD = 4'd2;

   // classification of one transaction, passed front to back
   typedef struct packed {
      logic near_mid;
      logic near_rgt;
      logic near_lft;
      logic clr_mid;
      logic clr_rgt;
      logic clr_lft;
      logic gest_mid;
      logic gest_lft;
      logic tilt;
      logic crash;
   } class_type;

   // {left, right} vibrator drive for a pattern step
   function automatic logic [1:0] pattern_drive(input logic [3:0] step);
      logic [1:0] drv;
      case (step)
         4'd1, 4'd3: drv = 2'b11;
         4'd4, 4'd6: drv = 2'b01;
         4'd7, 4'd9: drv = 2'b10;
         default:    drv = 2'b00;
      endcase
      return drv;
   endfunction

   function automatic logic pattern_final(input logic [3:0] step);
      return (step == 4'd3) || (step == 4'd6) || (step == 4'd9);
   endfunction

   function automatic logic [3:0] blink_advance(input logic [3:0] n);
      logic [4:0] nx;
      nx = {1'b0, n} + 5'd1;
      if (n == 4'd0) return 4'd0;
      return (nx >= {1'b0, BLINK_END}) ? 4'd0 : nx[3:0];
   endfunction

   function automatic logic blink_lit(input logic [3:0] n);
      return ((n >= 4'd2) && (n <= 4'd4)) || ((n >= 4'd6) && (n <= 4'd8));
   endfunction

endpackage

### rtl/core/phac_front.sv
// Front end: holds the threshold registers and classifies each request transaction.
// Depends on phac_pkg.
module phac_front
   import phac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  logic [DIST_W-1:0]     middle_cm,
   input  logic [DIST_W-1:0]     right_cm,
   input  logic [DIST_W-1:0]     left_cm,
   input  logic signed [ACCEL_W-1:0] accel_x,
   input  logic signed [ACCEL_W-1:0] accel_y,
   input  logic signed [ACCEL_W-1:0] accel_z,
   output class_type             cls
);

   logic [DIST_W-1:0]  near_ff, clear_ff, gest_ff;
   logic [LIMIT_W-1:0] tilt_ff, crash_ff;

   logic signed [2*ACCEL_W-1:0] sq_x, sq_y, sq_z;
   logic [MAG_W-1:0]            mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= NEAR_RST;
         clear_ff <= CLEAR_RST;
         gest_ff  <= GEST_RST;
         tilt_ff  <= TILT_RST;
         crash_ff <= CRASH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NEAR_CM:     near_ff  <= csr_wdata[DIST_W-1:0];
            CSR_CLEAR_CM:    clear_ff <= csr_wdata[DIST_W-1:0];
            CSR_GESTURE_CM:  gest_ff  <= csr_wdata[DIST_W-1:0];
            CSR_TILT_LIMIT:  tilt_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_CRASH_LIMIT: crash_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // squares are at most 16384, so the low 15 bits carry them
   assign sq_x = accel_x * accel_x;
   assign sq_y = accel_y * accel_y;
   assign sq_z = accel_z * accel_z;
   assign mag  = {2'b00, sq_x[14:0]} + {2'b00, sq_y[14:0]} + {2'b00, sq_z[14:0]};

   always_comb begin
      cls.near_mid = middle_cm < near_ff;
      cls.near_rgt = right_cm  < near_ff;
      cls.near_lft = left_cm   < near_ff;
      cls.clr_mid  = middle_cm > clear_ff;
      cls.clr_rgt  = right_cm  > clear_ff;
      cls.clr_lft  = left_cm   > clear_ff;
      cls.gest_mid = middle_cm < gest_ff;
      cls.gest_lft = left_cm   < gest_ff;
      cls.tilt     = (mag > {1'b0, tilt_ff}) && !accel_y[ACCEL_W-1] && (accel_y != '0);
      cls.crash    = mag > {1'b0, crash_ff};
   end

endmodule

### rtl/core/phac_queue.sv
// Short FIFO of classified transactions between front and back.
// Depends on phac_pkg and the assertion header.
`include "proximity_haptic_alert_controller_unit_assert.svh"
module phac_queue
   import phac_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_data,
   output logic      full,
   input  logic      pop,
   output class_type pop_data,
   output logic      empty
);

   class_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic [Q_PTR_W-1:0] ptr_gap;
   logic               do_push, do_pop;

   assign full     = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign ptr_gap  = wr_ptr_ff - rd_ptr_ff;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `PHAC_ASSERT_NOW(q_count_bound, clock, reset, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))
   `PHAC_ASSERT_NOW(q_ptr_gap, clock, reset, !full, count_ff[Q_PTR_W-1:0] == ptr_gap)

endmodule

### rtl/core/phac_back.sv
// Back end: warning, haptic pattern, blink and crash state plus the result register.
// Depends on phac_pkg and the assertion header.
`include "proximity_haptic_alert_controller_unit_assert.svh"
module phac_back
   import phac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  class_type             cls,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       crash_ff, crash_in;
   logic       warn_mid_ff, warn_mid_in;
   logic       warn_rgt_ff, warn_rgt_in;
   logic       warn_lft_ff, warn_lft_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] hold_ff, hold_in;
   logic [3:0] lblink_ff, lblink_in;
   logic [3:0] rblink_ff, rblink_in;
   logic [3:0] ctick_ff, ctick_in;
   logic       valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;

   logic       vib_l, vib_r, led, sos;
   logic [3:0] step_arm;
   logic [1:0] drv;

   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      crash_in    = crash_ff;
      warn_mid_in = warn_mid_ff;
      warn_rgt_in = warn_rgt_ff;
      warn_lft_in = warn_lft_ff;
      step_in     = step_ff;
      hold_in     = hold_ff;
      lblink_in   = lblink_ff;
      rblink_in   = rblink_ff;
      ctick_in    = ctick_ff;
      vib_l       = 1'b0;
      vib_r       = 1'b0;
      led         = 1'b0;
      sos         = 1'b0;
      step_arm    = step_ff;
      drv         = 2'b00;
      if (!crash_ff) begin
         led = cls.tilt;
         if (cls.crash) begin
            crash_in = 1'b1;
            ctick_in = '0;
         end
         // one new warning per transaction, middle first
         if (cls.near_mid && !warn_mid_ff) begin
            warn_mid_in = 1'b1;
            step_arm    = STEP_MID;
         end else if (cls.near_rgt && !warn_rgt_ff) begin
            warn_rgt_in = 1'b1;
            step_arm    = STEP_RIGHT;
         end else if (cls.near_lft && !warn_lft_ff) begin
            warn_lft_in = 1'b1;
            step_arm    = STEP_LEFT;
         end
         drv   = pattern_drive(step_arm);
         vib_l = drv[1];
         vib_r = drv[0];
         if (step_arm > STEP_LAST) begin
            step_in = STEP_IDLE;
            hold_in = '0;
         end else if (step_arm != STEP_IDLE) begin
            if (hold_ff >= HOLD_LAST) begin
               hold_in = '0;
               step_in = pattern_final(step_arm) ? STEP_IDLE : step_arm + 4'd1;
            end else begin
               step_in = step_arm;
               hold_in = hold_ff + 2'd1;
            end
         end else begin
            step_in = STEP_IDLE;
         end
         if (cls.clr_mid) warn_mid_in = 1'b0;
         if (cls.clr_lft) warn_lft_in = 1'b0;
         if (cls.clr_rgt) warn_rgt_in = 1'b0;
         // right blink follows the middle sensor
         lblink_in = blink_advance((cls.gest_lft && lblink_ff == '0) ? 4'd1 : lblink_ff);
         rblink_in = blink_advance((cls.gest_mid && rblink_ff == '0) ? 4'd1 : rblink_ff);
      end else begin
         vib_l = 1'b1;
         vib_r = 1'b1;
         led   = !ctick_ff[0];
         if (ctick_ff >= SOS_TICK) begin
            sos      = 1'b1;
            ctick_in = SOS_RELOAD;
         end else begin
            ctick_in = ctick_ff + 4'd1;
         end
      end
      data_in = {1'b0, sos, crash_in, led, blink_lit(rblink_in), blink_lit(lblink_in),
                 vib_r, vib_l};
      if (q_pop) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crash_ff    <= 1'b0;
         warn_mid_ff <= 1'b0;
         warn_rgt_ff <= 1'b0;
         warn_lft_ff <= 1'b0;
         step_ff     <= STEP_IDLE;
         hold_ff     <= '0;
         lblink_ff   <= '0;
         rblink_ff   <= '0;
         ctick_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop) begin
            crash_ff    <= crash_in;
            warn_mid_ff <= warn_mid_in;
            warn_rgt_ff <= warn_rgt_in;
            warn_lft_ff <= warn_lft_in;
            step_ff     <= step_in;
            hold_ff     <= hold_in;
            lblink_ff   <= lblink_in;
            rblink_ff   <= rblink_in;
            ctick_ff    <= ctick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   `PHAC_ASSERT_NEXT(bk_crash_sticks, clock, reset, crash_ff, crash_ff)
   `PHAC_ASSERT_NOW(bk_sos_in_crash, clock, reset, valid_ff && data_ff[6], data_ff[5])
   `PHAC_ASSERT_NEXT(bk_hold, clock, reset, valid_ff && !rsp_tready, valid_ff && $stable(data_ff))

endmodule

### rtl/core/proximity_haptic_alert_controller_unit.sv
// Proximity haptic alert controller: front classifier, transaction queue, back end.
// Requests are classified on acceptance, queued, then popped into the result register;
// throughput 1 transaction per cycle unless the response side stalls.
// The 4-entry queue lets the request side run on while the response side stalls.
// Reset: synchronous, active high; thresholds to defaults, alert and queue state clear.
module proximity_haptic_alert_controller_unit
   import phac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // middle_cm, right_cm, left_cm, accel_x, accel_y, accel_z, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vib_left, vib_right, left_signal, right_signal, status_led, crashed, send_sos, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   class_type front_cls, back_cls;
   logic      q_full, q_empty, q_pop;

   phac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .middle_cm (req_tdata[11:0]),
      .right_cm  (req_tdata[23:12]),
      .left_cm   (req_tdata[35:24]),
      .accel_x   (req_tdata[43:36]),
      .accel_y   (req_tdata[51:44]),
      .accel_z   (req_tdata[59:52]),
      .cls       (front_cls)
   );

   assign req_tready = !q_full;

   phac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_cls),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (back_cls),
      .empty     (q_empty)
   );

   phac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cls        (back_cls),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/phac_checker.sv
// Scoreboard for the proximity haptic alert controller: watches the CSR port and both
// streams, keeps its own copy of thresholds and alert state, and compares every response.
// Depends on phac_pkg for widths and register indexes only.
`timescale 1ns / 1ps
module phac_checker
   import phac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct {
      logic [DIST_W-1:0]         mid;
      logic [DIST_W-1:0]         rgt;
      logic [DIST_W-1:0]         lft;
      logic signed [ACCEL_W-1:0] ax;
      logic signed [ACCEL_W-1:0] ay;
      logic signed [ACCEL_W-1:0] az;
   } sensor_type;

   // vib_left sits in bit 0
   typedef struct packed {
      logic send_sos;
      logic crashed;
      logic status_led;
      logic right_signal;
      logic left_signal;
      logic vib_right;
      logic vib_left;
   } alert_type;

   logic [DIST_W-1:0]  near_th, clear_th, gest_th;
   logic [LIMIT_W-1:0] tilt_th, crash_th;

   logic       crash_mode, warn_mid, warn_rgt, warn_lft;
   logic [3:0] step, blink_l, blink_r, crash_tick;
   logic [1:0] hold;

   alert_type  pending_alerts[$];
   alert_type  got, want;
   sensor_type sample;

   function automatic logic blink_on(input logic [3:0] n);
      return (n >= 4'd2 && n <= 4'd4) || (n >= 4'd6 && n <= 4'd8);
   endfunction

   function automatic logic [3:0] blink_next(input logic [3:0] n);
      if (n == 4'd0) return 4'd0;
      return (n >= 4'd8) ? 4'd0 : n + 4'd1;
   endfunction

   // one tick of the controller; updates the shadow state
   function automatic alert_type predict_alert(input sensor_type s);
      alert_type o;
      int        x, y, z, mag;
      o   = '0;
      x   = s.ax;
      y   = s.ay;
      z   = s.az;
      mag = x * x + y * y + z * z;
      if (!crash_mode) begin
         o.status_led = (mag > int'(tilt_th)) && (y > 0);
         // the latching tick still runs the normal logic below
         if (mag > int'(crash_th)) begin
            crash_mode = 1'b1;
            crash_tick = 4'd0;
         end
         if (s.mid < near_th && !warn_mid) begin
            warn_mid = 1'b1;
            step     = 4'd1;
         end else if (s.rgt < near_th && !warn_rgt) begin
            warn_rgt = 1'b1;
            step     = 4'd4;
         end else if (s.lft < near_th && !warn_lft) begin
            warn_lft = 1'b1;
            step     = 4'd7;
         end
         case (step)
            4'd1, 4'd3: begin
               o.vib_left  = 1'b1;
               o.vib_right = 1'b1;
            end
            4'd4, 4'd6: o.vib_right = 1'b1;
            4'd7, 4'd9: o.vib_left  = 1'b1;
            default: ;
         endcase
         // hold count survives a restart of the step
         if (step > 4'd9) begin
            step = 4'd0;
            hold = 2'd0;
         end else if (step != 4'd0) begin
            if (hold >= 2'd2) begin
               hold = 2'd0;
               step = (step == 4'd3 || step == 4'd6 || step == 4'd9) ? 4'd0 : step + 4'd1;
            end else begin
               hold = hold + 2'd1;
            end
         end
         if (s.mid > clear_th) warn_mid = 1'b0;
         if (s.lft > clear_th) warn_lft = 1'b0;
         if (s.rgt > clear_th) warn_rgt = 1'b0;
         // right blink is started by the middle sensor
         if (s.lft < gest_th && blink_l == 4'd0) blink_l = 4'd1;
         if (s.mid < gest_th && blink_r == 4'd0) blink_r = 4'd1;
         blink_l = blink_next(blink_l);
         blink_r = blink_next(blink_r);
      end else begin
         o.vib_left   = 1'b1;
         o.vib_right  = 1'b1;
         o.status_led = !crash_tick[0];
         if (crash_tick >= 4'd10) begin
            o.send_sos = 1'b1;
            crash_tick = 4'd2;
         end else begin
            crash_tick = crash_tick + 4'd1;
         end
      end
      o.left_signal  = blink_on(blink_l);
      o.right_signal = blink_on(blink_r);
      o.crashed      = crash_mode;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         near_th    = 12'd10;
         clear_th   = 12'd20;
         gest_th    = 12'd5;
         tilt_th    = 16'd4000;
         crash_th   = 16'd14400;
         crash_mode = 1'b0;
         warn_mid   = 1'b0;
         warn_rgt   = 1'b0;
         warn_lft   = 1'b0;
         step       = 4'd0;
         hold       = 2'd0;
         blink_l    = 4'd0;
         blink_r    = 4'd0;
         crash_tick = 4'd0;
         pending_alerts.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_NEAR_CM:     near_th  = csr_wdata[DIST_W-1:0];
               CSR_CLEAR_CM:    clear_th = csr_wdata[DIST_W-1:0];
               CSR_GESTURE_CM:  gest_th  = csr_wdata[DIST_W-1:0];
               CSR_TILT_LIMIT:  tilt_th  = csr_wdata[LIMIT_W-1:0];
               CSR_CRASH_LIMIT: crash_th = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = alert_type'(rsp_tdata[6:0]);
            if (pending_alerts.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("%t: response %b with no transaction outstanding", $realtime, got);
            end else begin
               want = pending_alerts.pop_front();
               if (got.vib_left !== want.vib_left || got.vib_right !== want.vib_right ||
                   got.left_signal !== want.left_signal ||
                   got.right_signal !== want.right_signal ||
                   got.status_led !== want.status_led || got.crashed !== want.crashed ||
                   got.send_sos !== want.send_sos) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display({"%t: mismatch vib_l/r %b%b sig_l/r %b%b led %b crash %b sos %b",
                               " expected vib_l/r %b%b sig_l/r %b%b led %b crash %b sos %b"},
                              $realtime, got.vib_left, got.vib_right, got.left_signal,
                              got.right_signal, got.status_led, got.crashed, got.send_sos,
                              want.vib_left, want.vib_right, want.left_signal,
                              want.right_signal, want.status_led, want.crashed,
                              want.send_sos);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            sample.mid = req_tdata[11:0];
            sample.rgt = req_tdata[23:12];
            sample.lft = req_tdata[35:24];
            sample.ax  = req_tdata[43:36];
            sample.ay  = req_tdata[51:44];
            sample.az  = req_tdata[59:52];
            pending_alerts.push_back(predict_alert(sample));
         end
      end
      outstanding <= pending_alerts.size();
   end

endmodule

### tb/testbench.sv
// Top of the haptic alert controller testbench: clock, reset, CSR phases and stream stimulus.
// Depends on phac_pkg, the controller RTL and phac_checker, which predicts and compares.
`timescale 1ns / 1ps
module testbench;
   import phac_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int snd_idle_pct = 14;
   int rcv_idle_pct = 77;

   // thresholds as last written, used only to aim the stimulus
   logic [DIST_W-1:0] near_set  = 12'd10;
   logic [DIST_W-1:0] clear_set = 12'd20;
   logic [DIST_W-1:0] gest_set  = 12'd5;
   logic [DIST_W-1:0] cur_mid   = 12'd4095;
   logic [DIST_W-1:0] cur_rgt   = 12'd4095;
   logic [DIST_W-1:0] cur_lft   = 12'd4095;

   proximity_haptic_alert_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   phac_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // call just after a rising edge; returns in the step of acceptance
   task automatic send_sensor(input logic [11:0] mid, rgt, lft, input logic [7:0] ax, ay, az);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, az, ay, ax, lft, rgt, mid};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // distance registers get junk in the unused top bits; spare indexes get junk too
   task automatic set_config(input logic [11:0] near_v, clear_v, gest_v,
                             input logic [15:0] tilt_v, crash_v);
      drain_results();
      csr_write(CSR_NEAR_CM,     {4'($urandom), near_v});
      csr_write(CSR_CLEAR_CM,    {4'($urandom), clear_v});
      csr_write(CSR_GESTURE_CM,  {4'($urandom), gest_v});
      csr_write(CSR_TILT_LIMIT,  tilt_v);
      csr_write(CSR_CRASH_LIMIT, crash_v);
      for (int i = int'(CSR_CRASH_LIMIT) + 1; i < (1 << CSR_IDX_W); i++)
         csr_write(CSR_IDX_W'(i), 16'($urandom));
      near_set  = near_v;
      clear_set = clear_v;
      gest_set  = gest_v;
   endtask

   function automatic logic [11:0] pick_dist();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 1) ? 0 : 4095;
         1, 2, 3: v = int'(near_set) + int'($urandom_range(0, 4)) - 2;
         4, 5:    v = int'(clear_set) + int'($urandom_range(0, 4)) - 2;
         6:       v = int'(gest_set) + int'($urandom_range(0, 4)) - 2;
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   function automatic logic [7:0] pick_accel();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'(int'($urandom_range(0, 100)) - 50);
         5, 6, 7:       return 8'($urandom);
         8:             return $urandom_range(0, 1) ? 8'h80 : 8'h7f;
         default:       return 8'h00;
      endcase
   endfunction

   // mostly held distances so warnings, patterns and blinks run their course
   task automatic random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_sensor(12'($urandom), 12'($urandom), 12'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            if ($urandom_range(0, 99) < 30) cur_mid = pick_dist();
            if ($urandom_range(0, 99) < 30) cur_rgt = pick_dist();
            if ($urandom_range(0, 99) < 30) cur_lft = pick_dist();
            send_sensor(cur_mid, cur_rgt, cur_lft, pick_accel(), pick_accel(), pick_accel());
         end
      end
   endtask

   initial begin
      logic [11:0] base;
      logic [15:0] crash_pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: arming order, threshold ties, clearing, blinks, tilt edge
      send_sensor(12'd4095, 12'd4095, 12'd4095, 8'sd0, 8'sd0, 8'sd0);
      send_sensor(12'd9, 12'd4095, 12'd4095, 8'sd0, 8'sd70, 8'sd0);
      send_sensor(12'd9, 12'd9, 12'd4095, 8'sd0, -8'sd70, 8'sd0);
      send_sensor(12'd9, 12'd9, 12'd9, 8'sd20, 8'sd60, 8'sd0);
      send_sensor(12'd10, 12'd20, 12'd21, 8'sd21, 8'sd60, 8'sd0);
      send_sensor(12'd4, 12'd4095, 12'd4, 8'sd0, 8'sd0, 8'sd0);
      repeat (7) send_sensor(12'd4095, 12'd4095, 12'd4095, 8'sd0, 8'sd0, 8'sd0);
      send_sensor(12'd0, 12'd0, 12'd0, -8'sd50, -8'sd50, -8'sd50);

      // widest accelerations with the crash limit at the top of the magnitude range
      set_config(12'd10, 12'd20, 12'd5, 16'd0, 16'd49152);
      send_sensor(12'd4095, 12'd4095, 12'd4095, -8'sd128, -8'sd128, -8'sd128);
      send_sensor(12'd0, 12'd4095, 12'd0, 8'sd0, 8'sd1, 8'sd0);
      send_sensor(12'd4095, 12'd0, 12'd4095, 8'sd0, 8'sd0, 8'sd0);
      send_sensor(12'd0, 12'd0, 12'd0, 8'sd127, 8'sd127, 8'sd127);
      send_sensor(12'd4095, 12'd4095, 12'd4095, -8'sd128, -8'sd1, 8'sd127);
      send_sensor(12'd4095, 12'd4095, 12'd4095, 8'sd1, -8'sd128, 8'sd0);
      send_sensor(12'd4095, 12'd4095, 12'd4095, 8'sd0, 8'sd0, -8'sd128);

      set_config(12'd10, 12'd20, 12'd5, 16'd4000, 16'hffff);
      random_items(150);
      set_config(12'd4095, 12'd4095, 12'd4095, 16'd0, 16'hffff);
      random_items(75);
      drain_results();
      random_items(75);
      set_config(12'd0, 12'd0, 12'd0, 16'hffff, 16'd49152);
      random_items(150);

      snd_idle_pct = 77;
      rcv_idle_pct = 14;
      base = 12'($urandom_range(0, 200));
      set_config(base, base + 12'($urandom_range(0, 100)), 12'($urandom_range(0, 100)),
                 16'd49152, 16'hffff);
      random_items(150);
      set_config(12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom), 16'hffff);
      random_items(150);
      // clear threshold below the near one
      set_config(12'd100, 12'd50, 12'd300, 16'd2000, 16'hffff);
      random_items(150);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      base = 12'($urandom_range(5, 60));
      set_config(base, base + 12'($urandom_range(0, 30)), 12'($urandom_range(0, 40)),
                 16'($urandom_range(0, 8000)), 16'hffff);
      random_items(150);
      // crash mode latches for good here
      crash_pick = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(9000, 20000));
      set_config(12'd10, 12'd20, 12'd5, 16'd4000, crash_pick);
      random_items(150);

      drain_results();
      repeat (6) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/phac_pkg.sv
rtl/core/phac_front.sv
rtl/core/phac_queue.sv
rtl/core/phac_back.sv
rtl/core/proximity_haptic_alert_controller_unit.sv
tb/phac_checker.sv
tb/testbench.sv
